// File: rtl/lhb_pkg.sv
package lhb_pkg;

	// Field and register widths
	localparam int ACT_W     = 2;
	localparam int DUR_W     = 40;
	localparam int PCT_W     = 7;
	localparam int IDX_W     = 11;
	localparam int WID_W     = 10;
	localparam int HITS_W    = 32;
	localparam int TIME_W    = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 11;

	localparam int MAX_BINS_DEF = 1024;

	// Divider: the divisor is at least 1000 (> 2^9), so a 40-bit duration
	// yields a quotient below 2^31. The remainder stays below 1023 * 1000.
	localparam int US_PER_MS = 1000;
	localparam int Q_W       = 31;
	localparam int DIVR_W    = 20;
	localparam int DIV_STEPS = Q_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int LOG_W     = 5;

	// Register reset values
	localparam logic [IDX_W-1:0] LIMIT_RST = IDX_W'(100);
	localparam logic [WID_W-1:0] WIDTH_RST = WID_W'(100);
	localparam logic             LOG_RST   = 1'b0;
	localparam logic [PCT_W-1:0] PCT_RST   = PCT_W'(5);

	// Action codes
	localparam logic [ACT_W-1:0] ACT_RECORD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIN_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_MODE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PCT = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOGI,
		ST_LOG,
		ST_BIN,
		ST_FETCH,
		ST_UPD,
		ST_READ,
		ST_RDOUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic log_init;
		logic log_step;
		logic bin_sel;
		logic ram_rd;
		logic upd;
		logic res_zero;
		logic res_read;
		logic clr_init;
		logic clr_step;
	} dp_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             keep;
		logic             log_mode;
		logic             div_last;
		logic             log_done;
		logic             clr_last;
	} dp_sts_t;

endpackage

// File: rtl/lhb_ram.sv
module lhb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/lhb_datapath.sv
module lhb_datapath #(
	parameter int MAX_BINS = lhb_pkg::MAX_BINS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lhb_pkg::dp_cmd_t              cmd,
	output lhb_pkg::dp_sts_t              sts,
	input  logic                          cfg_we,
	input  logic [lhb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lhb_pkg::CFG_W-1:0]     cfg_data,
	input  logic [lhb_pkg::ACT_W-1:0]     action,
	input  logic [lhb_pkg::DUR_W-1:0]     duration_us,
	input  logic [lhb_pkg::PCT_W-1:0]     sample_draw,
	input  logic [lhb_pkg::IDX_W-1:0]     read_index,
	output logic                          done,
	output logic                          recorded,
	output logic [lhb_pkg::IDX_W-1:0]     bin_index,
	output logic [lhb_pkg::HITS_W-1:0]    bin_hits,
	output logic [lhb_pkg::TIME_W-1:0]    bin_time_us,
	output logic [lhb_pkg::HITS_W-1:0]    total_hits,
	output logic [lhb_pkg::TIME_W-1:0]    total_time_us
);
	import lhb_pkg::*;

	localparam int IW    = $clog2(MAX_BINS + 1);
	localparam int CW    = (IW > IDX_W) ? IW : IDX_W;
	localparam int RAM_W = HITS_W + TIME_W;

	function automatic logic [IW-1:0] clamp_idx(input logic [IDX_W-1:0] v);
		logic [IW-1:0] r;
		if (CW'(v) > CW'(MAX_BINS)) begin
			r = IW'(MAX_BINS);
		end else begin
			r = IW'(v);
		end
		return r;
	endfunction

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [DUR_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W + 1)'(b);
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	function automatic logic [HITS_W-1:0] sat_inc(input logic [HITS_W-1:0] a);
		return (a == '1) ? a : a + HITS_W'(1);
	endfunction

	// configuration
	logic [IDX_W-1:0] limit_q;
	logic [WID_W-1:0] width_q;
	logic             log_q;
	logic [PCT_W-1:0] pct_q;

	// divider and log shifter
	logic [DUR_W-1:0]  dur_q;
	logic [DIVR_W-1:0] div_q;
	logic [DIVR_W-1:0] rem_q;
	logic [Q_W-1:0]    dvd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [Q_W:0]      v_q;
	logic [LOG_W-1:0]  k_q;
	logic [IW-1:0]     bin_q;

	// store clearing and totals
	logic [IW-1:0]     clr_addr_q;
	logic [HITS_W-1:0] tot_hits_q;
	logic [TIME_W-1:0] tot_time_q;

	// result word
	logic              res_vld_q;
	logic              rec_q;
	logic [IDX_W-1:0]  idx_q;
	logic [HITS_W-1:0] bh_q;
	logic [TIME_W-1:0] bt_q;

	logic [IW-1:0]     lim;
	logic [WID_W-1:0]  wid_eff;
	logic [DIVR_W:0]   trial;
	logic              ge;
	logic [31:0]       bin_cand;
	logic [IW-1:0]     bin_nxt;
	logic [IW-1:0]     ram_addr;
	logic [RAM_W-1:0]  ram_wdata;
	logic [RAM_W-1:0]  ram_rdata;
	logic [HITS_W-1:0] rd_hits;
	logic [TIME_W-1:0] rd_time;
	logic [HITS_W-1:0] new_hits;
	logic [TIME_W-1:0] new_time;

	assign lim     = clamp_idx(limit_q);
	assign wid_eff = (width_q == '0) ? WID_W'(1) : width_q;

	// restoring division, one quotient bit per step
	assign trial = {rem_q, dvd_q[Q_W-1]} - {1'b0, div_q};
	assign ge    = ~trial[DIVR_W];

	assign bin_cand = log_q ? 32'(k_q) : 32'(dvd_q);
	assign bin_nxt  = (bin_cand >= 32'(lim)) ? lim : IW'(bin_cand);

	assign rd_hits  = ram_rdata[HITS_W-1:0];
	assign rd_time  = ram_rdata[RAM_W-1:HITS_W];
	assign new_hits = sat_inc(rd_hits);
	assign new_time = sat_add(rd_time, dur_q);

	assign ram_addr  = cmd.clr_step ? clr_addr_q : bin_q;
	assign ram_wdata = cmd.clr_step ? '0 : {new_time, new_hits};

	lhb_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_BINS + 1)
	) u_store (
		.clk  (clk),
		.we   (cmd.clr_step | cmd.upd),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.re   (cmd.ram_rd),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			width_q <= WIDTH_RST;
			log_q   <= LOG_RST;
			pct_q   <= PCT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIN_LIMIT:  limit_q <= cfg_data[IDX_W-1:0];
				REG_BIN_WIDTH:  width_q <= cfg_data[WID_W-1:0];
				REG_LOG_MODE:   log_q   <= cfg_data[0];
				REG_SAMPLE_PCT: pct_q   <= cfg_data[PCT_W-1:0];
				default:        limit_q <= limit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			tot_hits_q <= '0;
			tot_time_q <= '0;
			res_vld_q  <= 1'b0;
			cnt_q      <= '0;
		end else begin
			res_vld_q <= cmd.upd | cmd.res_zero | cmd.res_read;
			if (cmd.clr_init) begin
				clr_addr_q <= '0;
				tot_hits_q <= '0;
				tot_time_q <= '0;
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + IW'(1);
			end else if (cmd.upd) begin
				tot_hits_q <= sat_inc(tot_hits_q);
				tot_time_q <= sat_add(tot_time_q, dur_q);
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dur_q <= duration_us;
			div_q <= DIVR_W'(wid_eff) * DIVR_W'(US_PER_MS);
			rem_q <= DIVR_W'(duration_us[DUR_W-1:Q_W]);
			dvd_q <= duration_us[Q_W-1:0];
			bin_q <= clamp_idx(read_index);
		end else begin
			if (cmd.div_step) begin
				rem_q <= ge ? trial[DIVR_W-1:0] : {rem_q[DIVR_W-2:0], dvd_q[Q_W-1]};
				dvd_q <= {dvd_q[Q_W-2:0], ge};
			end
			if (cmd.bin_sel) begin
				bin_q <= bin_nxt;
			end
		end
		if (cmd.log_init) begin
			v_q <= {1'b0, dvd_q} + (Q_W + 1)'(1);
			k_q <= '0;
		end else if (cmd.log_step) begin
			v_q <= v_q >> 1;
			k_q <= k_q + LOG_W'(1);
		end
		if (cmd.upd) begin
			rec_q <= 1'b1;
			idx_q <= IDX_W'(bin_q);
			bh_q  <= new_hits;
			bt_q  <= new_time;
		end else if (cmd.res_read) begin
			rec_q <= 1'b0;
			idx_q <= IDX_W'(bin_q);
			bh_q  <= rd_hits;
			bt_q  <= rd_time;
		end else if (cmd.res_zero) begin
			rec_q <= 1'b0;
			idx_q <= '0;
			bh_q  <= '0;
			bt_q  <= '0;
		end
	end

	always_comb begin
		sts.act      = action;
		sts.keep     = (lim != '0) && (sample_draw < pct_q);
		sts.log_mode = log_q;
		sts.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
		sts.log_done = (v_q[Q_W:1] == '0);
		sts.clr_last = (clr_addr_q == IW'(MAX_BINS));
	end

	assign done          = res_vld_q;
	assign recorded      = rec_q;
	assign bin_index     = idx_q;
	assign bin_hits      = bh_q;
	assign bin_time_us   = bt_q;
	assign total_hits    = tot_hits_q;
	assign total_time_us = tot_time_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> bin_q <= lim)
		else $error("record bin beyond overflow bin");
endmodule

// File: rtl/lhb_ctrl.sv
module lhb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cfg_we,
	output logic             busy,
	input  lhb_pkg::dp_sts_t sts,
	output lhb_pkg::dp_cmd_t cmd
);
	import lhb_pkg::*;

	state_t state_q, state_d;
	logic   rpt_q, rpt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			rpt_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rpt_q   <= rpt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rpt_d   = rpt_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE) || cfg_we;
		if (cfg_we) begin
			// any register write wipes the store; no word comes out of it
			cmd.clr_init = 1'b1;
			rpt_d        = 1'b0;
			state_d      = ST_CLEAR;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd.load = 1'b1;
						case (sts.act)
							ACT_RECORD: begin
								if (sts.keep) begin
									state_d = ST_DIV;
								end else begin
									cmd.res_zero = 1'b1;
								end
							end
							ACT_CLEAR: begin
								cmd.clr_init = 1'b1;
								rpt_d        = 1'b1;
								state_d      = ST_CLEAR;
							end
							ACT_READ: begin
								state_d = ST_READ;
							end
							default: begin
								cmd.res_zero = 1'b1;
							end
						endcase
					end
				end
				ST_DIV: begin
					cmd.div_step = 1'b1;
					if (sts.div_last) begin
						state_d = sts.log_mode ? ST_LOGI : ST_BIN;
					end
				end
				ST_LOGI: begin
					cmd.log_init = 1'b1;
					state_d      = ST_LOG;
				end
				ST_LOG: begin
					if (sts.log_done) begin
						state_d = ST_BIN;
					end else begin
						cmd.log_step = 1'b1;
					end
				end
				ST_BIN: begin
					cmd.bin_sel = 1'b1;
					state_d     = ST_FETCH;
				end
				ST_FETCH: begin
					cmd.ram_rd = 1'b1;
					state_d    = ST_UPD;
				end
				ST_UPD: begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
				ST_READ: begin
					cmd.ram_rd = 1'b1;
					state_d    = ST_RDOUT;
				end
				ST_RDOUT: begin
					cmd.res_read = 1'b1;
					state_d      = ST_IDLE;
				end
				ST_CLEAR: begin
					cmd.clr_step = 1'b1;
					if (sts.clr_last) begin
						cmd.res_zero = rpt_q;
						rpt_d        = 1'b0;
						state_d      = ST_IDLE;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && !cfg_we && sts.act == ACT_READ)
		|=> state_q == ST_READ)
		else $error("read word accepted but no fetch started");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.upd, cmd.res_zero, cmd.res_read}))
		else $error("two result sources in one cycle");
endmodule

// File: rtl/latency_histogram_binner_unit.sv
// Sampled latency histogram. A word is taken at a rising edge with start high
// and busy low; each word yields exactly one result word, shown for a single
// cycle with done high, and the receiver cannot stall it, so capture the
// result fields whenever done is seen. The totals ports always show the
// current running totals. A record that is sampled out, or the unused action
// code, is answered straight from idle; a read fetches its bin from the
// store and then shows it; a kept record runs the 31-step bit-serial divider
// for the quotient q, in log mode the one-bit-per-cycle log shifter for
// floor(log2(1+q)), then reads and updates its bin through the single store
// port. A clear word, any register write and reset run a clearing pass over
// the store's MAX_BINS+1 bins (one bin per cycle) during which busy stays
// high; the clear word then strobes an all-zero result, a register write and
// reset strobe nothing. Registers are written with cfg_we and take effect at
// once; write them only while no word is in flight.
module latency_histogram_binner_unit #(
	parameter int MAX_BINS = lhb_pkg::MAX_BINS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command side
	input  logic                          start,
	output logic                          busy,
	input  logic [lhb_pkg::ACT_W-1:0]     action,
	input  logic [lhb_pkg::DUR_W-1:0]     duration_us,
	input  logic [lhb_pkg::PCT_W-1:0]     sample_draw,
	input  logic [lhb_pkg::IDX_W-1:0]     read_index,
	// register write port
	input  logic                          cfg_we,
	input  logic [lhb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lhb_pkg::CFG_W-1:0]     cfg_data,
	// result side
	output logic                          done,
	output logic                          recorded,
	output logic [lhb_pkg::IDX_W-1:0]     bin_index,
	output logic [lhb_pkg::HITS_W-1:0]    bin_hits,
	output logic [lhb_pkg::TIME_W-1:0]    bin_time_us,
	output logic [lhb_pkg::HITS_W-1:0]    total_hits,
	output logic [lhb_pkg::TIME_W-1:0]    total_time_us
);
	import lhb_pkg::*;

	// controller drives one-hot-ish commands, datapath answers with status
	dp_cmd_t cmd;
	dp_sts_t sts;

	lhb_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cfg_we(cfg_we),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	// divider, log shifter, bin store, totals and the result word
	lhb_datapath #(
		.MAX_BINS(MAX_BINS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.duration_us  (duration_us),
		.sample_draw  (sample_draw),
		.read_index   (read_index),
		.done         (done),
		.recorded     (recorded),
		.bin_index    (bin_index),
		.bin_hits     (bin_hits),
		.bin_time_us  (bin_time_us),
		.total_hits   (total_hits),
		.total_time_us(total_time_us)
	);
endmodule

// File: test/testbench.sv
module testbench;
	import lhb_pkg::*;

	// Store depth matches the default build: MAX_BINS regular bins plus overflow.
	localparam int BINS = MAX_BINS_DEF;
	// Action code 3 has no function; the block must leave its state alone.
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
	localparam logic [DUR_W-1:0] DUR_MAX = '1;
	// Long enough to cover any word still in flight after the last
	// strobe.
	localparam int DRAIN_CYCLES = 80;
	// The slowest correct run sends about 450 words with the longest gaps and
	// runs about 40 clearing passes for register writes and clear words; this
	// limit leaves several times the time that takes.
	localparam int CYCLE_LIMIT = 1_000_000;

	// One result word, field by field.
	typedef struct packed {
		logic              rec;
		logic [IDX_W-1:0]  idx;
		logic [HITS_W-1:0] hits;
		logic [TIME_W-1:0] tsum;
		logic [HITS_W-1:0] thits;
		logic [TIME_W-1:0] ttime;
	} bin_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [ACT_W-1:0]     action;
	logic [DUR_W-1:0]     duration_us;
	logic [PCT_W-1:0]     sample_draw;
	logic [IDX_W-1:0]     read_index;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 done;
	logic                 recorded;
	logic [IDX_W-1:0]     bin_index;
	logic [HITS_W-1:0]    bin_hits;
	logic [TIME_W-1:0]    bin_time_us;
	logic [HITS_W-1:0]    total_hits;
	logic [TIME_W-1:0]    total_time_us;

	// Our own copy of the histogram: per-bin counts and sums, running totals.
	logic [HITS_W-1:0] hit_count [0:BINS];
	logic [TIME_W-1:0] time_sum  [0:BINS];
	logic [HITS_W-1:0] hits_all;
	logic [TIME_W-1:0] time_all;

	// Shadow of the four registers.
	logic [IDX_W-1:0] limit_reg;
	logic [WID_W-1:0] width_reg;
	logic             log_reg;
	logic [PCT_W-1:0] pct_reg;

	// Expected result words in issue order; the block answers in order.
	bin_result_t pending_results [$];
	bin_result_t oldest;

	int errors;
	int cycle_count;
	int words_sent;
	int words_checked;
	int kept_records;
	int reads_sent;
	int clears_sent;
	int other_sent;
	int reg_writes;
	int saturated_sums;
	logic gaps_on;

	latency_histogram_binner_unit #(
		.MAX_BINS(BINS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.duration_us(duration_us),
		.sample_draw(sample_draw),
		.read_index(read_index),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.recorded(recorded),
		.bin_index(bin_index),
		.bin_hits(bin_hits),
		.bin_time_us(bin_time_us),
		.total_hits(total_hits),
		.total_time_us(total_time_us)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: a hung handshake or a lost result word ends up here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected",
				cycle_count, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Histogram predictor
	// ------------------------------------------------------------------

	function automatic void clear_histogram();
		for (int i = 0; i <= BINS; i++) begin
			hit_count[i] = '0;
			time_sum[i]  = '0;
		end
		hits_all = '0;
		time_all = '0;
	endfunction

	function automatic logic [HITS_W-1:0] inc_sat(input logic [HITS_W-1:0] h);
		return (&h) ? h : h + HITS_W'(1);
	endfunction

	// 48-bit sum of a 48-bit time total and a 40-bit duration, pinned at all-ones.
	function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
		input logic [DUR_W-1:0] d);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W + 1)'(d);
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	// Applies one accepted word to the shadow histogram, returns its result.
	function automatic bin_result_t histogram_step(input logic [ACT_W-1:0] act,
		input logic [DUR_W-1:0] dur, input logic [PCT_W-1:0] draw,
		input logic [IDX_W-1:0] ridx);
		bin_result_t r;
		logic [IDX_W-1:0] lim;
		logic [DUR_W-1:0] divisor;
		logic [DUR_W-1:0] q;
		logic [DUR_W-1:0] v;
		int unsigned bin;
		r = '0;
		// Limits past the store depth pin at the overflow bin.
		lim = (limit_reg > BINS) ? IDX_W'(BINS) : limit_reg;
		case (act)
			ACT_RECORD: begin
				if (lim != '0 && draw < pct_reg) begin
					// A zero width counts as 1 ms.
					divisor = (width_reg == '0) ? DUR_W'(US_PER_MS)
						: DUR_W'(width_reg) * DUR_W'(US_PER_MS);
					q = dur / divisor;
					if (log_reg) begin
						// floor(log2(q + 1)) by shifting down to one
						bin = 0;
						v = q + DUR_W'(1);
						while (v > 1) begin
							v = v >> 1;
							bin++;
						end
					end else begin
						bin = q[31:0];
					end
					if (bin >= lim)
						bin = lim;
					hit_count[bin] = inc_sat(hit_count[bin]);
					time_sum[bin]  = add_sat(time_sum[bin], dur);
					hits_all = inc_sat(hits_all);
					time_all = add_sat(time_all, dur);
					if (&time_sum[bin])
						saturated_sums++;
					r.rec  = 1'b1;
					r.idx  = IDX_W'(bin);
					r.hits = hit_count[bin];
					r.tsum = time_sum[bin];
					kept_records++;
				end else begin
					other_sent++;
				end
			end
			ACT_CLEAR: begin
				clear_histogram();
				clears_sent++;
			end
			ACT_READ: begin
				r.idx  = (ridx > BINS) ? IDX_W'(BINS) : ridx;
				r.hits = hit_count[r.idx];
				r.tsum = time_sum[r.idx];
				reads_sent++;
			end
			default: begin
				other_sent++;
			end
		endcase
		r.thits = hits_all;
		r.ttime = time_all;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("MISMATCH at cycle %0d, result word %0d: %s got %0h expected %0h",
			cycle_count, words_checked, what, got, want);
	endtask

	// done marks one word for exactly one cycle; it cannot be held off, so
	// every strobe is taken at the edge that closes its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, bin_index", 64'(bin_index), 64'd0);
			end else begin
				oldest = pending_results.pop_front();
				if (recorded !== oldest.rec)
					report_mismatch("recorded", 64'(recorded), 64'(oldest.rec));
				if (bin_index !== oldest.idx)
					report_mismatch("bin_index", 64'(bin_index), 64'(oldest.idx));
				if (bin_hits !== oldest.hits)
					report_mismatch("bin_hits", 64'(bin_hits), 64'(oldest.hits));
				if (bin_time_us !== oldest.tsum)
					report_mismatch("bin_time_us", 64'(bin_time_us), 64'(oldest.tsum));
				if (total_hits !== oldest.thits)
					report_mismatch("total_hits", 64'(total_hits), 64'(oldest.thits));
				if (total_time_us !== oldest.ttime)
					report_mismatch("total_time_us", 64'(total_time_us),
						64'(oldest.ttime));
				words_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Presents one word and holds it until busy is low at an edge. start
	// stays high afterward unless a gap is taken, so back-to-back words see
	// no dead cycle between them.
	task automatic send_word(input logic [ACT_W-1:0] act, input logic [DUR_W-1:0] dur,
		input logic [PCT_W-1:0] draw, input logic [IDX_W-1:0] ridx);
		start       <= 1'b1;
		action      <= act;
		duration_us <= dur;
		sample_draw <= draw;
		read_index  <= ridx;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(histogram_step(act, dur, draw, ridx));
		words_sent++;
		// Take a gap after about 22% of the words; mostly short gaps, now and then long
		// enough to land deep inside a divide or a clearing pass.
		if (gaps_on && $urandom_range(0, 99) < 22) begin
			start <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
				: $urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// Drops start and waits until every expected word has arrived and the
	// block is no longer busy.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Register write; it wipes the store, so the shadow is cleared too and
	// we wait out the clearing pass before moving on.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] data);
		wait_idle();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BIN_LIMIT:  limit_reg = data[IDX_W-1:0];
			REG_BIN_WIDTH:  width_reg = data[WID_W-1:0];
			REG_LOG_MODE:   log_reg   = data[0];
			REG_SAMPLE_PCT: pct_reg   = data[PCT_W-1:0];
			default: ;
		endcase
		clear_histogram();
		reg_writes++;
		// busy is already high with the write and stays high through the clearing pass
		repeat (2) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic apply_setting(input logic [CFG_W-1:0] lim, input logic [CFG_W-1:0] wid,
		input logic [CFG_W-1:0] lmode, input logic [CFG_W-1:0] pct);
		write_register(REG_BIN_LIMIT, lim);
		write_register(REG_BIN_WIDTH, wid);
		write_register(REG_LOG_MODE, lmode);
		write_register(REG_SAMPLE_PCT, pct);
	endtask

	// Random traffic under the current setting. Most words are records with
	// a draw that passes sampling, so the store actually fills up; reads
	// mostly land in the live bin range. near_max pushes durations to the
	// top of the 40-bit range so the 48-bit sums reach saturation.
	task automatic random_traffic(input int n_words, input logic allow_clear,
		input logic near_max);
		logic [ACT_W-1:0] act;
		logic [DUR_W-1:0] dur;
		logic [PCT_W-1:0] draw;
		logic [IDX_W-1:0] ridx;
		logic [63:0] raw;
		int roll;
		int lim;
		for (int n = 0; n < n_words; n++) begin
			roll = $urandom_range(0, 99);
			if (near_max)
				act = (roll < 94) ? ACT_RECORD : (roll < 98) ? ACT_READ : ACT_NOP;
			else if (roll < 70)
				act = ACT_RECORD;
			else if (roll < 92)
				act = ACT_READ;
			else if (roll < 95 && allow_clear)
				act = ACT_CLEAR;
			else
				act = ACT_NOP;

			raw = {$urandom(), $urandom()};
			if (near_max && $urandom_range(0, 9) != 0)
				dur = DUR_MAX - DUR_W'($urandom_range(0, 1 << 20));
			else if ($urandom_range(0, 9) == 0)
				dur = raw[DUR_W-1:0];
			else
				dur = DUR_W'(raw >> $urandom_range(24, 63)); // spread over magnitudes

			if (pct_reg != '0 && $urandom_range(0, 99) < 85)
				draw = PCT_W'($urandom_range(0, int'(pct_reg) - 1));
			else
				draw = PCT_W'($urandom_range(0, 127));

			lim = (limit_reg > BINS) ? BINS : int'(limit_reg);
			if ($urandom_range(0, 99) < 60)
				ridx = IDX_W'($urandom_range(0, lim));
			else
				ridx = IDX_W'($urandom_range(0, 2047));

			send_word(act, dur, draw, ridx);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset setting: 100 bins of 100 ms, linear, 5% sampling.
	task automatic test_reset_setting();
		send_word(ACT_RECORD, 40'd0, 7'd0, 11'd0);           // bin 0
		send_word(ACT_RECORD, 40'd99_999, 7'd4, 11'd0);      // still bin 0
		send_word(ACT_RECORD, 40'd100_000, 7'd3, 11'd0);     // bin 1
		send_word(ACT_RECORD, DUR_MAX, 7'd0, 11'd0);         // overflow bin
		send_word(ACT_RECORD, 40'd5, 7'd5, 11'd0);           // draw at pct: dropped
		send_word(ACT_RECORD, DUR_MAX, 7'd127, 11'h7FF);     // draw out of range
	endtask

	// Reads across the range, including indexes past the store, and the
	// unused action code.
	task automatic test_reads();
		send_word(ACT_READ, 40'd0, 7'd0, 11'd0);
		send_word(ACT_READ, 40'd0, 7'd0, 11'd100);
		send_word(ACT_READ, 40'd0, 7'd0, 11'd1024);
		send_word(ACT_READ, 40'd0, 7'd0, 11'd1025);
		send_word(ACT_READ, DUR_MAX, 7'h7F, 11'h7FF);
		send_word(ACT_NOP, DUR_MAX, 7'd0, 11'h555);
	endtask

	task automatic test_clear();
		send_word(ACT_CLEAR, DUR_MAX, 7'd0, 11'd100);
		send_word(ACT_READ, 40'd0, 7'd0, 11'd100);
	endtask

	// Corner settings: recording off, limit past the store, zero width,
	// log bins at their boundaries, sampling at both ends.
	task automatic test_corner_settings();
		write_register(REG_BIN_LIMIT, 11'd0);
		send_word(ACT_RECORD, 40'd12345, 7'd0, 11'd0);       // disabled
		apply_setting(11'h7FF, 11'd0, 11'd1, 11'd127);
		send_word(ACT_RECORD, 40'd0, 7'd0, 11'd0);           // log bin 0
		send_word(ACT_RECORD, 40'd1000, 7'd1, 11'd0);        // q=1 -> bin 1
		send_word(ACT_RECORD, 40'd2999, 7'd2, 11'd0);        // q=2 -> bin 1
		send_word(ACT_RECORD, 40'd3000, 7'd3, 11'd0);        // q=3 -> bin 2
		send_word(ACT_RECORD, DUR_MAX, 7'd0, 11'd0);         // largest log bin
		send_word(ACT_RECORD, 40'd777, 7'd126, 11'd0);       // just under pct
		send_word(ACT_RECORD, 40'd777, 7'd127, 11'd0);       // at pct: dropped
		send_word(ACT_READ, 40'd0, 7'd0, 11'h7FF);
		write_register(REG_SAMPLE_PCT, 11'd0);
		send_word(ACT_RECORD, 40'd1, 7'd0, 11'd0);           // nothing passes
	endtask

	// Several settings under random traffic, the extremes among them.
	task automatic test_random_settings();
		apply_setting(11'd100, 11'd1, 11'd0, 11'd100);
		random_traffic(20, 1'b1, 1'b0);
		apply_setting(11'd40, 11'd1, 11'd1, 11'd60);
		random_traffic(20, 1'b1, 1'b0);
		apply_setting(11'h7FF, 11'h7FF, 11'h7FE, 11'd127);   // width masks to 1023
		random_traffic(20, 1'b1, 1'b0);
		apply_setting(11'd1, 11'd0, 11'd1, 11'd1);
		random_traffic(20, 1'b1, 1'b0);
		apply_setting(CFG_W'($urandom_range(0, 2047)), CFG_W'($urandom_range(0, 2047)),
			CFG_W'($urandom_range(0, 2047)), CFG_W'($urandom_range(0, 2047)));
		random_traffic(20, 1'b1, 1'b0);
	endtask

	// Near-full durations into a few bins until both the overflow bin's
	// sum and the total pin at 2^48-1. Run without gaps: the long stretch
	// of back-to-back words.
	task automatic test_time_saturation();
		apply_setting(11'd8, 11'd1000, 11'd1, 11'd100);
		gaps_on = 1'b0;
		random_traffic(300, 1'b0, 1'b1);
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		action      = ACT_RECORD;
		duration_us = '0;
		sample_draw = '0;
		read_index  = '0;
		cfg_we      = 1'b0;
		cfg_index   = REG_BIN_LIMIT;
		cfg_data    = '0;
		errors         = 0;
		cycle_count    = 0;
		words_sent     = 0;
		words_checked  = 0;
		kept_records   = 0;
		reads_sent     = 0;
		clears_sent    = 0;
		other_sent     = 0;
		reg_writes     = 0;
		saturated_sums = 0;
		gaps_on        = 1'b1;
		limit_reg = LIMIT_RST;
		width_reg = WIDTH_RST;
		log_reg   = LOG_RST;
		pct_reg   = PCT_RST;
		clear_histogram();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The post-reset clearing pass holds busy; send_word waits it out.
		test_reset_setting();
		test_reads();
		test_clear();
		test_corner_settings();
		test_random_settings();
		test_time_saturation();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d words: %0d kept records, %0d reads, %0d clears, %0d dropped or no-op",
			words_sent, kept_records, reads_sent, clears_sent, other_sent);
		$display("Checked %0d result words over %0d register writes; %0d records hit a pinned sum",
			words_checked, reg_writes, saturated_sums);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", errors);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
